>>> rtl/mpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpd_pkg
// shared types and constants of the mouse packet decoder
// ----------------------------------------------------------------------------
package mpd_pkg;

  // protocol register codes
  localparam logic [2:0] PROTO_PS2_STD  = 3'd0;
  localparam logic [2:0] PROTO_PS2_WHL  = 3'd1;
  localparam logic [2:0] PROTO_HID_BOOT = 3'd2;
  localparam logic [2:0] PROTO_SERIAL   = 3'd3;
  localparam logic [2:0] PROTO_TOUCH_A  = 3'd4;
  localparam logic [2:0] PROTO_TOUCH_B  = 3'd5;

  localparam int PROTO_W   = 3;
  localparam int COUNT_W   = 3;
  localparam int PKT_BYTES = 6;   // highest byte any layout reads is byte 5

  localparam int BTN_W   = 5;
  localparam int DELTA_W = 14;
  localparam int WHEEL_W = 8;
  localparam int OUT_W   = 48;    // 41 payload bits padded to whole bytes

  typedef enum logic [1:0] {
    KIND_PS2,
    KIND_HID,
    KIND_SERIAL,
    KIND_TOUCH
  } kind_t;

  // completed packet handed from framing to decode
  typedef struct packed {
    logic                       fire;
    kind_t                      kind;
    logic                       has_wheel;
    logic [PKT_BYTES-1:0][7:0]  bytes;
  } frame_t;

  typedef struct packed {
    logic [WHEEL_W-1:0] delta_wheel;
    logic [DELTA_W-1:0] delta_y;
    logic [DELTA_W-1:0] delta_x;
    logic [BTN_W-1:0]   buttons;
  } report_t;

endpackage

>>> rtl/mpd_frame.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpd_frame
// packet framing: byte counter, packet byte store, completion detect
// ----------------------------------------------------------------------------
module mpd_frame #(
  parameter int REPORT_BYTES = 6
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_clear,
  input  logic [mpd_pkg::PROTO_W-1:0]    protocol,
  input  logic                           step,
  input  logic [7:0]                     data_byte,
  input  logic                           end_of_report,
  output mpd_pkg::frame_t                frame
);

  localparam logic [mpd_pkg::COUNT_W-1:0] CountLimit =
    mpd_pkg::COUNT_W'(REPORT_BYTES - 1);

  logic [mpd_pkg::COUNT_W-1:0] byte_count;
  logic [mpd_pkg::COUNT_W-1:0] byte_count_next;
  logic [mpd_pkg::COUNT_W-1:0] count_inc;
  logic [mpd_pkg::COUNT_W:0]   report_len;
  logic [7:0]                  packet_bytes [mpd_pkg::PKT_BYTES];
  logic                        wr;

  assign count_inc  = byte_count + 1'b1;
  assign report_len = {1'b0, byte_count} + 1'b1;

  always_comb begin
    wr              = 1'b0;
    byte_count_next = byte_count;
    frame.fire      = 1'b0;
    frame.kind      = mpd_pkg::KIND_PS2;
    frame.has_wheel = 1'b0;
    if (step) begin
      unique case (protocol)
        mpd_pkg::PROTO_PS2_STD, mpd_pkg::PROTO_PS2_WHL: begin
          frame.kind      = mpd_pkg::KIND_PS2;
          frame.has_wheel = (protocol == mpd_pkg::PROTO_PS2_WHL);
          if (byte_count != '0 || data_byte[3]) begin
            wr = 1'b1;
            if (count_inc == ((protocol == mpd_pkg::PROTO_PS2_WHL) ? 3'd4 : 3'd3)) begin
              byte_count_next = '0;
              frame.fire      = 1'b1;
            end else begin
              byte_count_next = count_inc;
            end
          end
        end
        mpd_pkg::PROTO_SERIAL: begin
          frame.kind = mpd_pkg::KIND_SERIAL;
          if (byte_count != '0 || data_byte[6]) begin
            wr = 1'b1;
            if (count_inc == 3'd3) begin
              byte_count_next = '0;
              frame.fire      = 1'b1;
            end else begin
              byte_count_next = count_inc;
            end
          end
        end
        mpd_pkg::PROTO_HID_BOOT, mpd_pkg::PROTO_TOUCH_A, mpd_pkg::PROTO_TOUCH_B: begin
          frame.kind = (protocol == mpd_pkg::PROTO_HID_BOOT) ? mpd_pkg::KIND_HID
                                                              : mpd_pkg::KIND_TOUCH;
          if (!end_of_report) begin
            if (byte_count < CountLimit) begin
              wr              = 1'b1;
              byte_count_next = count_inc;
            end
          end else begin
            wr              = 1'b1;
            byte_count_next = '0;
            if (protocol == mpd_pkg::PROTO_HID_BOOT) begin
              frame.fire      = (report_len >= 4'd3);
              frame.has_wheel = (report_len >= 4'd4);
            end else begin
              frame.fire = (report_len >= 4'd6);
            end
          end
        end
        default: begin
          // unused codes drop every byte
        end
      endcase
    end
    // current byte is seen by the decoder in the same pass it is stored
    for (int k = 0; k < mpd_pkg::PKT_BYTES; k++) begin
      frame.bytes[k] = (wr && byte_count == mpd_pkg::COUNT_W'(k)) ? data_byte
                                                                 : packet_bytes[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_clear) begin
      byte_count <= '0;
    end else begin
      byte_count <= byte_count_next;
    end
  end

  // bytes beyond the last decoded position are counted but not kept
  always_ff @(posedge clk) begin
    for (int k = 0; k < mpd_pkg::PKT_BYTES; k++) begin
      if (wr && byte_count == mpd_pkg::COUNT_W'(k)) begin
        packet_bytes[k] <= data_byte;
      end
    end
  end

endmodule

>>> rtl/mpd_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpd_decode
// field extraction of a completed packet into a movement report
// ----------------------------------------------------------------------------
module mpd_decode (
  input  mpd_pkg::frame_t   frame,
  output mpd_pkg::report_t  report
);

  logic [7:0] b0, b1, b2, b3, b4, b5;
  logic [mpd_pkg::DELTA_W-1:0] ps2_y;

  assign b0 = frame.bytes[0];
  assign b1 = frame.bytes[1];
  assign b2 = frame.bytes[2];
  assign b3 = frame.bytes[3];
  assign b4 = frame.bytes[4];
  assign b5 = frame.bytes[5];

  // 9-bit two's complement, sign in the header byte
  assign ps2_y = {{5{b0[5]}}, b0[5], b2};

  always_comb begin
    unique case (frame.kind)
      mpd_pkg::KIND_PS2: begin
        report.buttons     = {2'b00, b0[2:0]};
        report.delta_x     = {{5{b0[4]}}, b0[4], b1};
        report.delta_y     = mpd_pkg::DELTA_W'(0) - ps2_y;   // flip to screen direction
        report.delta_wheel = frame.has_wheel ? {{4{b3[3]}}, b3[3:0]} : 8'h00;
      end
      mpd_pkg::KIND_SERIAL: begin
        report.buttons     = {3'b000, b0[4], b0[5]};
        report.delta_x     = {{6{b0[1]}}, b0[1:0], b1[5:0]};
        report.delta_y     = {{6{b0[3]}}, b0[3:2], b2[5:0]};
        report.delta_wheel = 8'h00;
      end
      mpd_pkg::KIND_HID: begin
        report.buttons     = b0[4:0];
        report.delta_x     = {{6{b1[7]}}, b1};
        report.delta_y     = {{6{b2[7]}}, b2};
        report.delta_wheel = frame.has_wheel ? b3 : 8'h00;
      end
      mpd_pkg::KIND_TOUCH: begin
        report.buttons     = {3'b000, b0[1:0]};
        report.delta_x     = {1'b0, b1[4:0], b2};
        report.delta_y     = {1'b0, b4[4:0], b5};
        report.delta_wheel = 8'h00;
      end
      default: begin
        report = '0;
      end
    endcase
  end

endmodule

>>> rtl/mouse_packet_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mouse_packet_decoder_core
// mouse byte stream to movement report decoder
// ----------------------------------------------------------------------------
// Takes one received mouse byte per word on the slave stream and sends one
// movement report on the master stream each time a packet completes. The
// protocol register picks the framing: ps/2 standard (3 bytes) and wheel
// (4 bytes) sync on header bit 3, serial two-button syncs on bit 6 (3 bytes),
// and hid boot and touchpad modes collect bytes up to the word marked with
// tlast. Codes 6 and 7 swallow every byte. Writing the register restarts
// framing; write it only while no word is in flight. Throughput is one byte
// per clock while the report output is not stalled; a byte that completes a
// packet goes through the input register, then framing and decode into the
// output register, where its report waits. The input side keeps accepting
// while a report waits for tready, until both stages are full.
// ----------------------------------------------------------------------------
module mouse_packet_decoder_core #(
  parameter int REPORT_BYTES = 6   // longest hid/touchpad report kept, 4..8
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic [2:0]  cfg_wdata,     // protocol
  // byte input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic        s_axis_tlast,  // end_of_report
  // report output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // [4:0] buttons, [18:5] delta_x,
                                     // [32:19] delta_y, [40:33] delta_wheel,
                                     // [47:41] zero
);

  logic [mpd_pkg::PROTO_W-1:0] protocol;

  // input register stage
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  // whole pipeline moves when the output register is free or draining
  logic advance;
  logic step;

  mpd_pkg::frame_t  frame;
  mpd_pkg::report_t report;

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign step          = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;

  // protocol select, restarts framing on write
  always_ff @(posedge clk) begin
    if (rst) begin
      protocol <= mpd_pkg::PROTO_PS2_STD;
    end else if (cfg_we) begin
      protocol <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  mpd_frame #(
    .REPORT_BYTES (REPORT_BYTES)
  ) u_frame (
    .clk           (clk),
    .rst           (rst),
    .cfg_clear     (cfg_we),
    .protocol      (protocol),
    .step          (step),
    .data_byte     (in_byte),
    .end_of_report (in_last),
    .frame         (frame)
  );

  mpd_decode u_decode (
    .frame  (frame),
    .report (report)
  );

  // output register: loads a report when a packet completes this pass
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= frame.fire;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && frame.fire) begin
      m_axis_tdata <= {7'b0, report};
    end
  end

endmodule

>>> rtl/mpd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpd_checker
// port level checks of the mouse packet decoder
// ----------------------------------------------------------------------------
module mpd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);

  // a held report keeps its word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("report changed while stalled");

  // padding above the report fields stays zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[47:41] == 7'd0)
    else $error("nonzero pad bits in report");

  // an empty output register never back-pressures the byte stream
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // a new report is preceded by an accepted byte
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("report without matching byte");

endmodule

bind mouse_packet_decoder_core mpd_checker u_mpd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

>>> bench/tb_mouse_packet_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mouse_packet_decoder_core
// self-checking bench for the mouse packet decoder
// ----------------------------------------------------------------------------
// A queue of mouse bytes is filled phase by phase, one phase per protocol
// setting, and fed to the byte stream by a clocked driver with random gaps.
// The monitor decodes every accepted byte with its own framing and field
// decode and keeps the reports it expects in order; each report taken from
// the master stream is checked field by field against the oldest one. The
// protocol register is only rewritten once the block has drained.
// ----------------------------------------------------------------------------
module tb_mouse_packet_decoder_core;

  // codes the package leaves out: the block swallows every byte under these
  localparam logic [2:0] PROTO_UNUSED_6 = 3'd6;
  localparam logic [2:0] PROTO_UNUSED_7 = 3'd7;

  localparam int RPT_BYTES     = 6;    // longest hid/touchpad report kept
  localparam int PHASE_ITEMS   = 160;  // random words per protocol phase
  localparam int SWALLOW_ITEMS = 40;   // shorter phases for the unused codes
  localparam int SETTLE_CYCLES = 8;    // two-stage pipe plus margin
  localparam int QUIET_LIMIT   = 500;  // cycles with no handshake at all

  typedef struct packed {
    logic [7:0] data;
    logic       eor;
  } mouse_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_wdata = mpd_pkg::PROTO_PS2_STD;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] data_byte
  logic        s_axis_tlast = 1'b0;    // end_of_report
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;           // [4:0] buttons, [18:5] delta_x,
                                       // [32:19] delta_y, [40:33] delta_wheel,
                                       // [47:41] zero

  // byte source and report bookkeeping
  mouse_byte_t      byte_q[$];
  mpd_pkg::report_t pending_reports[$];
  int               bytes_queued = 0;
  int               bytes_taken = 0;
  int               mismatches = 0;
  bit               idling = 1'b1;
  int               send_gap = 0;
  int               recv_stall = 0;
  int               quiet_cycles = 0;
  mouse_byte_t      next_byte;
  mpd_pkg::report_t want_rep;
  mpd_pkg::report_t got_rep;
  mpd_pkg::report_t new_rep;

  // decoder state as the block should hold it
  logic [2:0]  pred_proto;
  logic [2:0]  pred_count;
  logic [7:0]  pred_bytes [0:7];

  always #2 clk = ~clk;

  mouse_packet_decoder_core #(
    .REPORT_BYTES(RPT_BYTES)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // one accepted byte through framing and decode; returns 1 with the report
  // when the byte completes a packet
  function automatic bit decode_mouse_byte(input logic [7:0] b, input logic eor,
                                           output mpd_pkg::report_t rep);
    logic [2:0] slot;
    logic [2:0] need;
    int         len;
    bit         fire;
    slot = pred_count;
    fire = 1'b0;
    rep  = '0;
    case (pred_proto)
      mpd_pkg::PROTO_PS2_STD, mpd_pkg::PROTO_PS2_WHL: begin
        need = (pred_proto == mpd_pkg::PROTO_PS2_WHL) ? 3'd4 : 3'd3;
        // header must carry the sync bit, later bytes are taken as they come
        if (pred_count != 3'd0 || b[3]) begin
          pred_bytes[slot] = b;
          pred_count = pred_count + 3'd1;
          if (pred_count >= need) begin
            pred_count = 3'd0;
            fire = 1'b1;
            rep.buttons = {2'b00, pred_bytes[0][2:0]};
            // 9-bit movement, sign in the header, y flipped to screen direction
            rep.delta_x = {{6{pred_bytes[0][4]}}, pred_bytes[1]};
            rep.delta_y = -{{6{pred_bytes[0][5]}}, pred_bytes[2]};
            if (pred_proto == mpd_pkg::PROTO_PS2_WHL)
              rep.delta_wheel = {{4{pred_bytes[3][3]}}, pred_bytes[3][3:0]};
          end
        end
      end
      mpd_pkg::PROTO_SERIAL: begin
        if (pred_count != 3'd0 || b[6]) begin
          pred_bytes[slot] = b;
          pred_count = pred_count + 3'd1;
          if (pred_count >= 3'd3) begin
            pred_count = 3'd0;
            fire = 1'b1;
            rep.buttons = {3'b000, pred_bytes[0][4], pred_bytes[0][5]};
            rep.delta_x = {{6{pred_bytes[0][1]}}, pred_bytes[0][1:0], pred_bytes[1][5:0]};
            rep.delta_y = {{6{pred_bytes[0][3]}}, pred_bytes[0][3:2], pred_bytes[2][5:0]};
          end
        end
      end
      mpd_pkg::PROTO_HID_BOOT, mpd_pkg::PROTO_TOUCH_A, mpd_pkg::PROTO_TOUCH_B: begin
        if (!eor) begin
          // overlong reports drop the middle bytes once the buffer is nearly full
          if (pred_count < 3'(RPT_BYTES - 1)) begin
            pred_bytes[slot] = b;
            pred_count = pred_count + 3'd1;
          end
        end else begin
          pred_bytes[slot] = b;
          pred_count = 3'd0;
          len = int'(slot) + 1;
          if (pred_proto == mpd_pkg::PROTO_HID_BOOT) begin
            if (len >= 3) begin
              fire = 1'b1;
              rep.buttons = pred_bytes[0][4:0];
              rep.delta_x = {{6{pred_bytes[1][7]}}, pred_bytes[1]};
              rep.delta_y = {{6{pred_bytes[2][7]}}, pred_bytes[2]};
              if (len >= 4)
                rep.delta_wheel = pred_bytes[3];
            end
          end else if (len >= 6) begin
            fire = 1'b1;
            rep.buttons = {3'b000, pred_bytes[0][1:0]};
            rep.delta_x = {1'b0, pred_bytes[1][4:0], pred_bytes[2]};
            rep.delta_y = {1'b0, pred_bytes[4][4:0], pred_bytes[5]};
          end
        end
      end
      default: ;
    endcase
    return fire;
  endfunction

  // byte driver: holds a word until taken, random gaps while idling is on
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      send_gap <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (byte_q.size() != 0) begin
        if (idling && $urandom_range(0, 7) == 0) begin
          send_gap <= $urandom_range(0, 6);
          s_axis_tvalid <= 1'b0;
        end else begin
          next_byte = byte_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= next_byte.data;
          s_axis_tlast <= next_byte.eor;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // report sink: random stall bursts while idling is on
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      recv_stall <= 0;
    end else if (recv_stall != 0) begin
      recv_stall <= recv_stall - 1;
      m_axis_tready <= 1'b0;
    end else if (idling && $urandom_range(0, 5) == 0) begin
      recv_stall <= $urandom_range(0, 6);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // monitor: check reports first, then predict from the byte taken this edge
  always @(posedge clk) begin
    if (rst) begin
      pred_proto = mpd_pkg::PROTO_PS2_STD;
      pred_count = 3'd0;
    end else begin
      if (cfg_we) begin
        pred_proto = cfg_wdata;
        pred_count = 3'd0;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_rep = mpd_pkg::report_t'(m_axis_tdata[40:0]);
        if (pending_reports.size() == 0) begin
          report_mismatch($sformatf("unexpected report %h", m_axis_tdata));
        end else begin
          want_rep = pending_reports.pop_front();
          if (got_rep.buttons !== want_rep.buttons)
            report_mismatch($sformatf("buttons got %h want %h",
                                      got_rep.buttons, want_rep.buttons));
          if (got_rep.delta_x !== want_rep.delta_x)
            report_mismatch($sformatf("delta_x got %h want %h",
                                      got_rep.delta_x, want_rep.delta_x));
          if (got_rep.delta_y !== want_rep.delta_y)
            report_mismatch($sformatf("delta_y got %h want %h",
                                      got_rep.delta_y, want_rep.delta_y));
          if (got_rep.delta_wheel !== want_rep.delta_wheel)
            report_mismatch($sformatf("delta_wheel got %h want %h",
                                      got_rep.delta_wheel, want_rep.delta_wheel));
          if (m_axis_tdata[47:41] !== 7'd0)
            report_mismatch($sformatf("pad bits got %h", m_axis_tdata[47:41]));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        bytes_taken++;
        if (decode_mouse_byte(s_axis_tdata, s_axis_tlast, new_rep))
          pending_reports.push_back(new_rep);
      end
    end
  end

  // watchdog: any handshake restarts the count
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] data, input logic eor);
    mouse_byte_t w;
    w.data = data;
    w.eor  = eor;
    byte_q.push_back(w);
    bytes_queued++;
  endtask

  // every byte taken and every report out, then let bytes that give no
  // report clear the pipe before anything is written
  task automatic wait_quiet();
    while (bytes_taken != bytes_queued || pending_reports.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_protocol(input logic [2:0] proto);
    wait_quiet();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= proto;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // hand-picked packets: field extremes and the framing corner cases
  task automatic push_directed(input logic [2:0] proto);
    case (proto)
      mpd_pkg::PROTO_PS2_STD: begin
        push_byte(8'h00, 1'b0);   // no sync bit, skipped
        push_byte(8'h3F, 1'b1);   // all buttons, both sign bits: x -256, y +256
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b1);
      end
      mpd_pkg::PROTO_PS2_WHL: begin
        push_byte(8'h08, 1'b0);   // positive x/y at the top of range
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hF8, 1'b1);   // wheel nibble 8 -> -8
      end
      mpd_pkg::PROTO_HID_BOOT: begin
        push_byte(8'hFF, 1'b0);   // too short, no report
        push_byte(8'h7F, 1'b1);
        push_byte(8'hFF, 1'b0);   // three bytes, wheel reads zero
        push_byte(8'h80, 1'b0);
        push_byte(8'h7F, 1'b1);
      end
      mpd_pkg::PROTO_SERIAL: begin
        push_byte(8'h00, 1'b0);   // no start bit, skipped
        push_byte(8'h7F, 1'b0);   // start, both buttons
        push_byte(8'hFF, 1'b1);
        push_byte(8'hC0, 1'b0);   // bit 6 set but still taken as data
      end
      mpd_pkg::PROTO_TOUCH_A: begin
        push_byte(8'hFF, 1'b0);   // both coordinates at 8191
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b1);
      end
      default: push_byte(8'h08, 1'b1);
    endcase
  endtask

  // one random sequence: mostly well-formed packets, some noise and breakage
  task automatic push_sequence(input logic [2:0] proto);
    int         len;
    int         nominal;
    int         pick;
    logic [7:0] b;
    case (proto)
      mpd_pkg::PROTO_PS2_STD, mpd_pkg::PROTO_PS2_WHL, mpd_pkg::PROTO_SERIAL: begin
        if ($urandom_range(0, 7) == 0) begin
          push_byte(8'($urandom), 1'($urandom));
        end else begin
          len = (proto == mpd_pkg::PROTO_PS2_WHL) ? 4 : 3;
          if ($urandom_range(0, 9) == 0)
            len = $urandom_range(1, len - 1);   // cut short, framing slips
          for (int i = 0; i < len; i++) begin
            b = 8'($urandom);
            if (i == 0) begin
              if (proto == mpd_pkg::PROTO_SERIAL)
                b[6] = 1'b1;
              else
                b[3] = 1'b1;
            end
            push_byte(b, 1'($urandom));
          end
        end
      end
      mpd_pkg::PROTO_HID_BOOT, mpd_pkg::PROTO_TOUCH_A, mpd_pkg::PROTO_TOUCH_B: begin
        nominal = (proto == mpd_pkg::PROTO_HID_BOOT) ? $urandom_range(3, 4) : 6;
        pick = $urandom_range(0, 9);
        if (pick == 0)
          len = $urandom_range(1, nominal);     // short report
        else if (pick == 1)
          len = $urandom_range(nominal, 10);    // overlong report
        else
          len = nominal;
        for (int i = 0; i < len; i++)
          push_byte(8'($urandom), i == len - 1);
      end
      default: push_byte(8'($urandom), 1'($urandom));
    endcase
  endtask

  // one protocol setting: optional write, directed bytes, random traffic with
  // a full drain halfway through
  task automatic run_phase(input logic [2:0] proto, input bit do_write,
                           input bit directed, input int budget);
    int start;
    if (do_write)
      set_protocol(proto);
    if (directed)
      push_directed(proto);
    start = bytes_queued;
    while (bytes_queued - start < budget / 2)
      push_sequence(proto);
    wait_quiet();
    while (bytes_queued - start < budget)
      push_sequence(proto);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // first phase runs on the reset value of the register
    run_phase(mpd_pkg::PROTO_PS2_STD,  1'b0, 1'b1, PHASE_ITEMS);
    run_phase(mpd_pkg::PROTO_PS2_WHL,  1'b1, 1'b1, PHASE_ITEMS);
    run_phase(mpd_pkg::PROTO_HID_BOOT, 1'b1, 1'b1, PHASE_ITEMS);
    run_phase(mpd_pkg::PROTO_SERIAL,   1'b1, 1'b1, PHASE_ITEMS);
    run_phase(mpd_pkg::PROTO_TOUCH_A,  1'b1, 1'b1, PHASE_ITEMS);
    run_phase(mpd_pkg::PROTO_TOUCH_B,  1'b1, 1'b0, PHASE_ITEMS);
    run_phase(PROTO_UNUSED_6,          1'b1, 1'b1, SWALLOW_ITEMS);
    run_phase(mpd_pkg::PROTO_PS2_STD,  1'b1, 1'b0, PHASE_ITEMS);
    run_phase(mpd_pkg::PROTO_SERIAL,   1'b1, 1'b0, PHASE_ITEMS);
    run_phase(PROTO_UNUSED_7,          1'b1, 1'b0, SWALLOW_ITEMS);
    run_phase(mpd_pkg::PROTO_TOUCH_B,  1'b1, 1'b0, PHASE_ITEMS);
    run_phase(mpd_pkg::PROTO_PS2_WHL,  1'b1, 1'b0, PHASE_ITEMS);

    // last stretch at full rate on both sides
    set_protocol(mpd_pkg::PROTO_HID_BOOT);
    idling = 1'b0;
    run_phase(mpd_pkg::PROTO_HID_BOOT, 1'b0, 1'b0, PHASE_ITEMS);

    wait_quiet();
    if (mismatches == 0 && pending_reports.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
